// ----- rtl/core/pal_pkg.sv -----
package pal_pkg;

  // Default capacity of the list.
  localparam int MAX_ENTRIES_DEF = 64;

  // Field widths of the request and response items.
  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 6;
  localparam int LEN_W   = 7;

  // Operation codes carried by a request item.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_DELETE    = 3'd1,
    OP_OVERWRITE = 3'd2,
    OP_READ      = 3'd3,
    OP_FIND      = 3'd4,
    OP_REMOVE    = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  // Status codes carried by a response item.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDWAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [FIDX_W-1:0]        found_index;
    logic [LEN_W-1:0]         length;
  } rsp_item_t;

endpackage

// ----- rtl/core/pal_ram.sv -----
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/positional_array_list.sv -----
// Overwrite, clear, insert into an empty list and error cases go straight from the idle state
// to the response; read passes through the read-wait state first. A walk covers n entries,
// one entry per cycle: n is length - position for insert, length - position - 1 for delete
// and length for find and remove-all (find stops reading after its first match).
// Throughput: one item at a time; the next item is taken after the response leaves.
// Reset clears the length to zero and the control state; the entry memory is not cleared.
module positional_array_list import pal_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_t                state, state_next;
  op_t                   op_q, op_q_next;
  logic [DATA_W-1:0]     val_q, val_q_next;
  logic [AW-1:0]         pos_q, pos_q_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         rd_ptr, rd_ptr_next;
  logic [CW-1:0]         left, left_next;
  logic                  pend, pend_next;
  logic [AW-1:0]         pend_idx, pend_idx_next;
  logic [CW-1:0]         w_ptr, w_ptr_next;
  logic                  hit, hit_next;
  status_t               st_q, st_q_next;
  logic [DATA_W-1:0]     rd_q, rd_q_next;
  logic [FIDX_W-1:0]     fidx_q, fidx_q_next;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_W-1:0]     ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_W-1:0]     ram_rdata;

  logic [PW-1:0]         pos_e;
  logic [PW-1:0]         cnt_e;
  logic [AW-1:0]         pos_a;
  logic                  issue;
  logic                  match;

  pal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_e = PW'(req.position);
  assign cnt_e = PW'(count);
  assign pos_a = AW'(req.position);
  assign match = (ram_rdata == val_q);
  assign issue = (left != '0) && !((op_q == OP_FIND) && hit);

  // Handshake and response item.
  assign req_ready       = (state == S_IDLE);
  assign rsp_valid       = (state == S_RESP);
  assign rsp.status      = st_q;
  assign rsp.read_value  = rd_q;
  assign rsp.found_index = fidx_q;
  assign rsp.length      = LEN_W'(count);

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    op_q     <= op_q_next;
    val_q    <= val_q_next;
    pos_q    <= pos_q_next;
    rd_ptr   <= rd_ptr_next;
    left     <= left_next;
    pend_idx <= pend_idx_next;
    w_ptr    <= w_ptr_next;
    hit      <= hit_next;
    st_q     <= st_q_next;
    rd_q     <= rd_q_next;
    fidx_q   <= fidx_q_next;
  end

  // Sequencer: decodes an item and, for insert, delete, find and remove, walks the memory one entry per cycle.
  always_comb begin
    state_next    = state;
    op_q_next     = op_q;
    val_q_next    = val_q;
    pos_q_next    = pos_q;
    count_next    = count;
    rd_ptr_next   = rd_ptr;
    left_next     = left;
    pend_next     = 1'b0;
    pend_idx_next = pend_idx;
    w_ptr_next    = w_ptr;
    hit_next      = hit;
    st_q_next     = st_q;
    rd_q_next     = rd_q;
    fidx_q_next   = fidx_q;
    ram_we        = 1'b0;
    ram_waddr     = pos_q;
    ram_wdata     = val_q;
    ram_raddr     = rd_ptr;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_q_next   = op_t'(req.op);
          val_q_next  = req.value;
          st_q_next   = ST_OK;
          rd_q_next   = '0;
          fidx_q_next = '0;
          hit_next    = 1'b0;
          w_ptr_next  = '0;
          state_next  = S_RESP;
          case (op_t'(req.op))
            OP_INSERT: begin
              if (count == CW'(MAX_ENTRIES)) begin
                st_q_next = ST_FULL;
              end else if (count == '0) begin
                // An empty list always takes the item at slot zero.
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = req.value;
                count_next = CW'(1);
              end else if (pos_e <= cnt_e) begin
                pos_q_next  = pos_a;
                rd_ptr_next = AW'(count - CW'(1));
                left_next   = count - CW'(req.position);
                state_next  = S_SCAN;
              end else begin
                st_q_next = ST_BADPOS;
              end
            end
            OP_DELETE: begin
              if (count == '0) begin
                st_q_next = ST_EMPTY;
              end else if (pos_e < cnt_e) begin
                rd_ptr_next = pos_a + AW'(1);
                left_next   = count - CW'(req.position) - CW'(1);
                state_next  = S_SCAN;
              end else begin
                st_q_next = ST_BADPOS;
              end
            end
            OP_OVERWRITE: begin
              if (count == '0) begin
                st_q_next = ST_EMPTY;
              end else if (pos_e < cnt_e) begin
                ram_we    = 1'b1;
                ram_waddr = pos_a;
                ram_wdata = req.value;
              end else begin
                st_q_next = ST_BADPOS;
              end
            end
            OP_READ: begin
              if (count == '0) begin
                st_q_next = ST_EMPTY;
              end else if (pos_e < cnt_e) begin
                ram_raddr  = pos_a;
                state_next = S_RDWAIT;
              end else begin
                st_q_next = ST_BADPOS;
              end
            end
            OP_FIND: begin
              st_q_next   = ST_NOTFOUND;
              rd_ptr_next = '0;
              left_next   = count;
              state_next  = S_SCAN;
            end
            OP_REMOVE: begin
              rd_ptr_next = '0;
              left_next   = count;
              state_next  = S_SCAN;
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
              // Unused code: no change.
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read of the walk.
        if (issue) begin
          ram_raddr     = rd_ptr;
          pend_next     = 1'b1;
          pend_idx_next = rd_ptr;
          left_next     = left - CW'(1);
          if (op_q == OP_INSERT) begin
            rd_ptr_next = rd_ptr - AW'(1);
          end else begin
            rd_ptr_next = rd_ptr + AW'(1);
          end
        end

        // Consume the data read in the previous cycle.
        if (pend) begin
          case (op_q)
            OP_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pend_idx + AW'(1);
              ram_wdata = ram_rdata;
            end
            OP_DELETE: begin
              ram_we    = 1'b1;
              ram_waddr = pend_idx - AW'(1);
              ram_wdata = ram_rdata;
            end
            OP_FIND: begin
              if (match && !hit) begin
                hit_next    = 1'b1;
                st_q_next   = ST_OK;
                fidx_q_next = FIDX_W'(pend_idx);
              end
            end
            OP_REMOVE: begin
              if (!match) begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(w_ptr);
                ram_wdata  = ram_rdata;
                w_ptr_next = w_ptr + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end

        // Walk done: finish the operation.
        if (!issue && !pend) begin
          state_next = S_RESP;
          case (op_q)
            OP_INSERT: begin
              ram_we     = 1'b1;
              ram_waddr  = pos_q;
              ram_wdata  = val_q;
              count_next = count + CW'(1);
            end
            OP_DELETE: begin
              count_next = count - CW'(1);
            end
            OP_REMOVE: begin
              count_next = w_ptr;
            end
            default: begin
            end
          endcase
        end
      end

      S_RDWAIT: begin
        rd_q_next  = ram_rdata;
        state_next = S_RESP;
      end

      S_RESP: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
